@@ rtl/core/smro_pkg.sv @@
// ----------------------------------------------------------------------------
// Sliding mode rotor observer package
// Shared widths, the arctangent step table and saturation helpers.
// ----------------------------------------------------------------------------
package smro_pkg;

	localparam int DivW = 40;  // dividend and quotient width of the shared divider
	localparam int DsrW = 24;  // divisor width
	localparam int CorW = 27;  // CORDIC vector width
	localparam int MaxSteps = 24;

	typedef logic signed [23:0] s24_t;
	typedef logic signed [15:0] s16_t;

	// Arctangent of 2^-i in angle units, 65536 units per turn.
	function automatic logic [13:0] atan_units(input logic [4:0] i);
		logic [13:0] r;
		case (i)
			5'd0: r = 14'd8192;
			5'd1: r = 14'd4836;
			5'd2: r = 14'd2555;
			5'd3: r = 14'd1297;
			5'd4: r = 14'd651;
			5'd5: r = 14'd326;
			5'd6: r = 14'd163;
			5'd7: r = 14'd81;
			5'd8: r = 14'd41;
			5'd9: r = 14'd20;
			5'd10: r = 14'd10;
			5'd11: r = 14'd5;
			5'd12: r = 14'd3;
			5'd13: r = 14'd1;
			5'd14: r = 14'd1;
			default: r = 14'd0;
		endcase
		return r;
	endfunction

	function automatic s24_t sat24(input logic signed [51:0] v);
		s24_t r;
		if (v > 52'sd8388607) r = 24'sh7FFFFF;
		else if (v < -52'sd8388608) r = 24'sh800000;
		else r = v[23:0];
		return r;
	endfunction

	function automatic s16_t sat16(input logic signed [17:0] v);
		s16_t r;
		if (v > 18'sd32767) r = 16'sh7FFF;
		else if (v < -18'sd32768) r = 16'sh8000;
		else r = v[15:0];
		return r;
	endfunction

endpackage

@@ rtl/core/sliding_mode_rotor_observer.sv @@
// ----------------------------------------------------------------------------
// Sliding mode rotor observer
// Sensorless back-EMF angle and speed estimator for a PMSM, Q8.8 fixed point.
// ----------------------------------------------------------------------------
// One input beat is handled at a time and s_tready is low until its result
// is in the output register. A clear beat clears the observer state and goes
// straight to the output load. An update beat works through each axis in
// turn, running the 40-step shared divider for the gain when the current
// error lies inside the boundary layer, then the angle, one rotation per
// cycle, or held when both filtered EMFs are zero, then the speed filter,
// the pole-pair division and the output load, which waits for the output
// register to free up.
// A single 17 x 34 bit multiplier serves every product.
module sliding_mode_rotor_observer #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // volt_alpha, volt_beta, amp_alpha, amp_beta
	input  logic [0:0]  s_tuser,  // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,  // angle, elec_speed, mech_speed, emf_alpha_out,
	                              // emf_beta_out, zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import smro_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_MR   = 5'd1;
	localparam logic [4:0] ST_S    = 5'd2;
	localparam logic [4:0] ST_MK   = 5'd3;
	localparam logic [4:0] ST_I    = 5'd4;
	localparam logic [4:0] ST_E    = 5'd5;
	localparam logic [4:0] ST_G    = 5'd6;
	localparam logic [4:0] ST_DV   = 5'd7;
	localparam logic [4:0] ST_DW   = 5'd8;
	localparam logic [4:0] ST_F    = 5'd9;
	localparam logic [4:0] ST_FM   = 5'd10;
	localparam logic [4:0] ST_FA   = 5'd11;
	localparam logic [4:0] ST_ANG  = 5'd12;
	localparam logic [4:0] ST_CW   = 5'd13;
	localparam logic [4:0] ST_SP   = 5'd14;
	localparam logic [4:0] ST_SM   = 5'd15;
	localparam logic [4:0] ST_SA   = 5'd16;
	localparam logic [4:0] ST_MD   = 5'd17;
	localparam logic [4:0] ST_MW   = 5'd18;
	localparam logic [4:0] ST_OUT  = 5'd19;

	localparam logic [3:0] REG_RES  = 4'd0;
	localparam logic [3:0] REG_KL   = 4'd1;
	localparam logic [3:0] REG_GAIN = 4'd2;
	localparam logic [3:0] REG_BW   = 4'd3;
	localparam logic [3:0] REG_EFC  = 4'd4;
	localparam logic [3:0] REG_LIM  = 4'd5;
	localparam logic [3:0] REG_SFC  = 4'd6;
	localparam logic [3:0] REG_PP   = 4'd7;

	logic [4:0]  state_q;
	logic        ch_q;
	logic [15:0] res_q, kl_q, gain_q, bw_q, efc_q, lim_q, sfc_q;
	logic [4:0]  pp_q;
	logic [63:0] in_q;

	s24_t ihat_q [2];
	s16_t esw_q [2];
	s24_t filt_q [2];
	logic [15:0] held_q;
	logic signed [16:0] last_q, raw_q, mech_q;
	s24_t speed_q;

	logic signed [33:0] s_q;
	logic signed [24:0] err_q;
	logic signed [26:0] t_q;
	logic               neg_q;
	logic signed [50:0] prod_q;

	logic [15:0]        mul_a;
	logic signed [33:0] mul_b;
	logic signed [50:0] mul_p;

	logic               div_start;
	logic [DivW-1:0]    div_dividend, div_quo;
	logic [DsrW-1:0]    div_divisor;
	logic               div_done;
	logic               cor_start, cor_done;
	logic signed [16:0] cor_angle;

	logic signed [15:0] volt, amp;
	logic signed [24:0] bnd;
	logic signed [24:0] err_abs;
	logic signed [17:0] dif, lim18, dcl;
	logic signed [16:0] elec;
	logic [16:0]        elec_abs;
	logic signed [17:0] qs;
	logic               out_free;

	assign volt = ch_q ? $signed(in_q[31:16]) : $signed(in_q[15:0]);
	assign amp  = ch_q ? $signed(in_q[63:48]) : $signed(in_q[47:32]);
	assign bnd  = $signed({1'b0, bw_q, 8'h00});
	assign err_abs = (err_q < 0) ? -err_q : err_q;
	assign lim18 = $signed({2'b00, lim_q});
	assign dif   = 18'(raw_q) - 18'(last_q);
	assign dcl   = (dif > lim18) ? lim18 : ((dif < -lim18) ? -lim18 : dif);
	assign elec  = speed_q[23:7];
	assign elec_abs = (elec < 0) ? 17'(-18'(elec)) : elec;
	assign qs    = neg_q ? -18'($signed({1'b0, div_quo[16:0]}))
	                     : 18'($signed({1'b0, div_quo[16:0]}));
	assign out_free = !m_tvalid || m_tready;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// Operand select for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MR: begin
				mul_a = res_q;
				mul_b = 34'(ihat_q[ch_q]);
			end
			ST_MK: begin
				mul_a = kl_q;
				mul_b = s_q;
			end
			ST_G: begin
				mul_a = gain_q;
				mul_b = 34'(err_abs);
			end
			ST_FM: begin
				mul_a = efc_q;
				mul_b = 34'(t_q);
			end
			ST_SM: begin
				mul_a = sfc_q;
				mul_b = 34'(t_q);
			end
			default: begin
			end
		endcase
	end

	assign mul_p = 51'($signed({1'b0, mul_a})) * 51'(mul_b);

	assign div_start    = (state_q == ST_DV) || (state_q == ST_MD);
	assign div_dividend = (state_q == ST_MD) ? DivW'(elec_abs) : prod_q[DivW-1:0];
	assign div_divisor  = (state_q == ST_MD) ? ((pp_q == 5'd0) ? DsrW'(1) : DsrW'(pp_q))
	                                         : {bw_q, 8'h00};
	assign cor_start    = (state_q == ST_ANG) && !((filt_q[0] == 0) && (filt_q[1] == 0));

	smro_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	smro_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.x_in   (filt_q[0]),
		.y_in   (filt_q[1]),
		.done   (cor_done),
		.angle  (cor_angle)
	);

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (s_tvalid && s_tready) begin
			in_q <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ch_q     <= 1'b0;
			res_q    <= 16'd256;
			kl_q     <= 16'd205;
			gain_q   <= 16'd1280;
			bw_q     <= 16'd26;
			efc_q    <= 16'd1029;
			lim_q    <= 16'd4096;
			sfc_q    <= 16'd328;
			pp_q     <= 5'd1;
			ihat_q   <= '{default: '0};
			esw_q    <= '{default: '0};
			filt_q   <= '{default: '0};
			held_q   <= '0;
			last_q   <= '0;
			raw_q    <= '0;
			speed_q  <= '0;
			mech_q   <= '0;
			s_q      <= '0;
			err_q    <= '0;
			t_q      <= '0;
			neg_q    <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_RES:  res_q  <= cfg_data;
					REG_KL:   kl_q   <= cfg_data;
					REG_GAIN: gain_q <= cfg_data;
					REG_BW:   bw_q   <= cfg_data;
					REG_EFC:  efc_q  <= cfg_data;
					REG_LIM:  lim_q  <= cfg_data;
					REG_SFC:  sfc_q  <= cfg_data;
					REG_PP:   pp_q   <= cfg_data[4:0];
					default: begin
					end
				endcase
			end
			if ((state_q == ST_OUT) && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						ch_q <= 1'b0;
						if (s_tuser[0]) begin
							ihat_q  <= '{default: '0};
							esw_q   <= '{default: '0};
							filt_q  <= '{default: '0};
							held_q  <= '0;
							last_q  <= '0;
							speed_q <= '0;
							mech_q  <= '0;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_MR;
						end
					end
				end
				ST_MR: state_q <= ST_S;
				ST_S: begin
					s_q <= $signed({{10{volt[15]}}, volt, 8'h00})
					     - 34'(prod_q >>> 8)
					     - $signed({{10{esw_q[ch_q][15]}}, esw_q[ch_q], 8'h00});
					state_q <= ST_MK;
				end
				ST_MK: state_q <= ST_I;
				ST_I: begin
					ihat_q[ch_q] <= sat24(52'(prod_q >>> 12) + 52'(ihat_q[ch_q]));
					state_q <= ST_E;
				end
				ST_E: begin
					err_q <= $signed({amp[15], amp, 8'h00}) - 25'(ihat_q[ch_q]);
					state_q <= ST_G;
				end
				ST_G: begin
					// Outside the boundary layer the switching EMF is the full gain.
					if (err_q > bnd) begin
						esw_q[ch_q] <= sat16($signed({2'b00, gain_q}));
						state_q <= ST_F;
					end else if (err_q < -bnd) begin
						esw_q[ch_q] <= sat16(-$signed({2'b00, gain_q}));
						state_q <= ST_F;
					end else if (bw_q == 16'd0) begin
						esw_q[ch_q] <= '0;
						state_q <= ST_F;
					end else begin
						neg_q   <= (err_q < 0);
						state_q <= ST_DV;
					end
				end
				ST_DV: state_q <= ST_DW;
				ST_DW: begin
					if (div_done) begin
						esw_q[ch_q] <= sat16(qs);
						state_q <= ST_F;
					end
				end
				ST_F: begin
					t_q <= 27'($signed({esw_q[ch_q], 8'h00})) - 27'(filt_q[ch_q]);
					state_q <= ST_FM;
				end
				ST_FM: state_q <= ST_FA;
				ST_FA: begin
					filt_q[ch_q] <= sat24(52'(prod_q >>> 16) + 52'(filt_q[ch_q]));
					if (ch_q) begin
						state_q <= ST_ANG;
					end else begin
						ch_q    <= 1'b1;
						state_q <= ST_MR;
					end
				end
				ST_ANG: begin
					// With no EMF at all the angle is held.
					if ((filt_q[0] == 0) && (filt_q[1] == 0)) begin
						raw_q   <= $signed({1'b0, held_q});
						state_q <= ST_SP;
					end else begin
						state_q <= ST_CW;
					end
				end
				ST_CW: begin
					if (cor_done) begin
						raw_q   <= cor_angle;
						state_q <= ST_SP;
					end
				end
				ST_SP: begin
					t_q <= 27'($signed({dcl, 7'h00})) - 27'(speed_q);
					state_q <= ST_SM;
				end
				ST_SM: state_q <= ST_SA;
				ST_SA: begin
					speed_q <= sat24(52'(prod_q >>> 16) + 52'(speed_q));
					last_q  <= raw_q;
					held_q  <= raw_q[15:0];
					state_q <= ST_MD;
				end
				ST_MD: begin
					neg_q   <= (elec < 0);
					state_q <= ST_MW;
				end
				ST_MW: begin
					if (div_done) begin
						mech_q  <= qs[16:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tdata  <= {6'b0, filt_q[1][23:8], filt_q[0][23:8],
						             mech_q, elec, held_q};
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_update_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser[0] |=> state_q == ST_MR)
		else $error("update beat did not start the current model");

	a_clear_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] |=> state_q == ST_OUT && speed_q == 0)
		else $error("clear beat did not clear the observer");

	a_cordic_done: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> state_q == ST_CW)
		else $error("CORDIC finished outside its wait state");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DW || state_q == ST_MW)
		else $error("divider finished outside a wait state");
`endif

endmodule

@@ rtl/core/smro_div.sv @@
// ----------------------------------------------------------------------------
// Shared unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smro_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [smro_pkg::DivW-1:0] dividend,
	input  logic [smro_pkg::DsrW-1:0] divisor,
	output logic                     done,
	output logic [smro_pkg::DivW-1:0] quotient
);
	import smro_pkg::*;

	logic [DsrW:0]   rem_q;
	logic [DivW-1:0] quo_q;
	logic [DsrW-1:0] dsr_q;
	logic [5:0]      cnt_q;
	logic            busy_q, done_q;
	logic [DsrW:0]   trial;
	logic            take;

	assign trial = {rem_q[DsrW-1:0], quo_q[DivW-1]};
	assign take  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DivW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? (trial - {1'b0, dsr_q}) : trial;
			quo_q <= {quo_q[DivW-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/core/smro_cordic.sv @@
// ----------------------------------------------------------------------------
// Vectoring CORDIC
// Iterative atan2 of the filtered EMF vector, one rotation per cycle.
// ----------------------------------------------------------------------------
module smro_cordic #(
	parameter int STEPS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  smro_pkg::s24_t      x_in,
	input  smro_pkg::s24_t      y_in,
	output logic                done,
	output logic signed [16:0]  angle
);
	import smro_pkg::*;

	logic signed [CorW-1:0] x_q, y_q, dx, dy;
	logic signed [17:0]     z_q, at;
	logic [4:0]             i_q;
	logic                   busy_q, done_q;

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = $signed({4'b0000, atan_units(i_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == 5'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// A vector in the left half plane is turned by half a turn first.
			if (x_in < 0) begin
				x_q <= -CorW'(x_in);
				y_q <= -CorW'(y_in);
				z_q <= (y_in >= 0) ? 18'sd32768 : -18'sd32768;
			end else begin
				x_q <= CorW'(x_in);
				y_q <= CorW'(y_in);
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end
		end
	end

	always_comb begin
		if (z_q > 18'sd32768) angle = 17'sd32768 - 17'sd1 + 17'sd1;
		else if (z_q < -18'sd32768) angle = -17'sd32768;
		else angle = z_q[16:0];
	end

	assign done = done_q;

endmodule
